>>> hdl/swm_pkg.sv
package swm_pkg;

   localparam int WSIZE_BITS = 7;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = 7'd1;

   localparam logic REG_WINDOW_SIZE = 1'b0;

endpackage

>>> hdl/swm_cell.sv
module swm_cell #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          advance,
   input  logic                          head,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [SAMPLE_BITS-1:0] prev_max,
   output logic signed [SAMPLE_BITS-1:0] max_in,
   output logic signed [SAMPLE_BITS-1:0] max_ff
);

   always_comb begin
      if (head) begin
         max_in = sample;
      end else if (prev_max > sample) begin
         max_in = prev_max;
      end else begin
         max_in = sample;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         max_ff <= max_in;
      end
   end

endmodule

>>> hdl/swm_chain.sv
module swm_chain #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 16,
   parameter int IDX_BITS    = 6
) (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [IDX_BITS-1:0]           start,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   output logic signed [SAMPLE_BITS-1:0] window_max
);

   logic signed [SAMPLE_BITS-1:0] cell_max_ff [WINDOW_MAX];
   logic signed [SAMPLE_BITS-1:0] cell_max_in [WINDOW_MAX];

   genvar i;
   generate
      for (i = 0; i < WINDOW_MAX; i++) begin : g_cell
         logic signed [SAMPLE_BITS-1:0] prev_max;
         logic                          head;

         if (i == 0) begin : g_first
            assign prev_max = sample;
         end else begin : g_rest
            assign prev_max = cell_max_ff[i-1];
         end

         assign head = (start == IDX_BITS'(i));

         swm_cell #(
            .SAMPLE_BITS(SAMPLE_BITS)
         ) u_cell (
            .clock   (clock),
            .advance (advance),
            .head    (head),
            .sample  (sample),
            .prev_max(prev_max),
            .max_in  (cell_max_in[i]),
            .max_ff  (cell_max_ff[i])
         );
      end
   endgenerate

   assign window_max = cell_max_in[WINDOW_MAX-1];

endmodule

>>> hdl/sliding_window_maximum.sv
// Sliding window maximum over a stream of signed samples.
// Input channel req_*: one sample per transaction in req_tdata, req_tuser set
// on the first sample of a sequence (restarts the window).
// Result channel rsp_*: one window maximum per input transaction once the
// current sequence holds window_size samples; earlier samples give nothing.
// Configuration: APB-style csr_* port, register window_size at address 0
// (0 acts as 1, values above WINDOW_MAX act as WINDOW_MAX). A write also
// restarts the sequence. Write only while no transaction is in flight.
// Throughput: one sample per cycle. Every sample enters a row of WINDOW_MAX
// max cells; cell j keeps the maximum of the samples since the window start
// cell, so the last cell yields the window maximum in the accept cycle.
// Latency: the result is registered, valid the cycle after acceptance.
// Stall: while a result waits and rsp_tready is low, req_tready is low.
// Reset: synchronous, active high; window_size returns to 1, sequence empty.
module sliding_window_maximum #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // sample
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        req_tdata,
   // first_of_sequence
   input  logic                                    req_tuser,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // window_max
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]        rsp_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [swm_pkg::CSR_ADDR_BITS-1:0]       csr_paddr,
   input  logic [swm_pkg::CSR_DATA_BITS-1:0]       csr_pwdata,
   output logic [swm_pkg::CSR_DATA_BITS-1:0]       csr_prdata,
   output logic                                    csr_pready
);

   import swm_pkg::*;

   localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int LEN_BITS   = $clog2(WINDOW_MAX + 1);
   localparam int IDX_BITS   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CMP_BITS   = (LEN_BITS > WSIZE_BITS) ? LEN_BITS : WSIZE_BITS;

   logic [WSIZE_BITS-1:0]         window_size_ff, window_size_in;
   logic [LEN_BITS-1:0]           win_len_ff, win_len_in;
   logic [IDX_BITS-1:0]           start_ff, start_in;
   logic [LEN_BITS-1:0]           fill_ff, fill_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_max_ff, rsp_max_in;

   logic                          csr_write;
   logic                          req_accept;
   logic [WSIZE_BITS-1:0]         wsize_new;
   logic [CMP_BITS-1:0]           len_wide;
   logic [LEN_BITS-1:0]           fill_base;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic signed [SAMPLE_BITS-1:0] window_max;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_WINDOW_SIZE) ?
                       CSR_DATA_BITS'(window_size_ff) : '0;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign sample     = $signed(req_tdata[SAMPLE_BITS-1:0]);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_BITS'($unsigned(rsp_max_ff));

   always_comb begin
      wsize_new = csr_pwdata[WSIZE_BITS-1:0];
      if (wsize_new == '0) begin
         len_wide = CMP_BITS'(1);
      end else if (CMP_BITS'(wsize_new) > CMP_BITS'(WINDOW_MAX)) begin
         len_wide = CMP_BITS'(WINDOW_MAX);
      end else begin
         len_wide = CMP_BITS'(wsize_new);
      end
   end

   always_comb begin
      window_size_in = window_size_ff;
      win_len_in     = win_len_ff;
      start_in       = start_ff;
      fill_in        = fill_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_max_in     = rsp_max_ff;
      fill_base      = req_tuser ? '0 : fill_ff;

      if (csr_write && csr_paddr[2] == REG_WINDOW_SIZE) begin
         window_size_in = wsize_new;
         win_len_in     = LEN_BITS'(len_wide);
         start_in       = IDX_BITS'(CMP_BITS'(WINDOW_MAX) - len_wide);
         fill_in        = '0;
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_accept) begin
         if (fill_base < win_len_ff) begin
            fill_in = fill_base + LEN_BITS'(1);
         end else begin
            fill_in = fill_base;
         end
         if (fill_in == win_len_ff) begin
            rsp_valid_in = 1'b1;
            rsp_max_in   = window_max;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WSIZE_RESET;
         win_len_ff     <= LEN_BITS'(1);
         start_ff       <= IDX_BITS'(WINDOW_MAX - 1);
         fill_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         window_size_ff <= window_size_in;
         win_len_ff     <= win_len_in;
         start_ff       <= start_in;
         fill_ff        <= fill_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_max_ff <= rsp_max_in;
   end

   swm_chain #(
      .WINDOW_MAX (WINDOW_MAX),
      .SAMPLE_BITS(SAMPLE_BITS),
      .IDX_BITS   (IDX_BITS)
   ) u_chain (
      .clock     (clock),
      .advance   (req_accept),
      .start     (start_ff),
      .sample    (sample),
      .window_max(window_max)
   );

endmodule
